### src/dvfs_governor_with_thermal_throttle_unit_macros.svh
// Assertion macros shared by the DVFS governor RTL.
`ifndef DVFS_GOVERNOR_WITH_THERMAL_THROTTLE_UNIT_MACROS_SVH
`define DVFS_GOVERNOR_WITH_THERMAL_THROTTLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DGTT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dvfs governor: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DGTT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dvfs governor: next-cycle check failed");

`endif

### src/dgtt_pkg.sv
// Types and constants of the DVFS governor with thermal throttle.
package dgtt_pkg;

   // Field widths
   localparam int CoreW = 6;
   localparam int TempW = 12;
   localparam int UtilW = 11;
   localparam int FreqW = 16;

   // Packed channel widths (tdata filled up to whole bytes)
   localparam int ReqDataW = 48;
   localparam int RspDataW = 24;

   // Configuration port
   localparam int CsrAddrW = 5;
   localparam int CsrDataW = 32;

   // Lowering ratio 70/100 as a reciprocal multiply: (old * ScaleRecip) >> ScaleShift
   // gives floor(old * 70 / 100) exactly for every 16-bit old frequency
   localparam int ScaleNum    = 70;
   localparam int ScaleDen    = 100;
   localparam int ScaleShift  = 20;
   localparam int ScaleRecipW = 20;
   localparam int ScaleRecip  = (ScaleNum * (2 ** ScaleShift) + ScaleDen - 1) / ScaleDen;
   localparam int ScaleProdW  = FreqW + ScaleRecipW;

   // Shared divider: dividend is the scaled frequency, 16 bits
   localparam int DivW     = 16;
   localparam int DivCntW  = 5;
   localparam logic [DivCntW-1:0] DivLastCount = DivCntW'(DivW - 1);

   // Register indexes
   localparam logic [2:0] RegMinFreq  = 3'd0;
   localparam logic [2:0] RegMaxFreq  = 3'd1;
   localparam logic [2:0] RegFreqStep = 3'd2;
   localparam logic [2:0] RegUpThr    = 3'd3;
   localparam logic [2:0] RegDownThr  = 3'd4;
   localparam logic [2:0] RegCritTemp = 3'd5;
   localparam logic [2:0] RegRecvTemp = 3'd6;

   // Reset values of the registers
   localparam logic [FreqW-1:0] MinFreqReset  = 16'd1000;
   localparam logic [FreqW-1:0] MaxFreqReset  = 16'd4000;
   localparam logic [FreqW-1:0] FreqStepReset = 16'd100;
   localparam logic [UtilW-1:0] UpThrReset    = 11'd717;
   localparam logic [UtilW-1:0] DownThrReset  = 11'd307;
   localparam logic signed [TempW-1:0] CritTempReset = 12'sd800;
   localparam logic signed [TempW-1:0] RecvTempReset = 12'sd780;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_CLAMP,
      ST_EMIT
   } state_type;

endpackage

### src/dvfs_governor_with_thermal_throttle_unit.sv
// Top level of the utilization-threshold DVFS governor with thermal throttle.
// Each item is one core's frequency decision for an epoch. The block takes one
// item at a time. For a throttled, inactive, high- or mid-utilization core the
// result is registered on acceptance; for a low-utilization core the old
// frequency is scaled by 7/10 by a reciprocal multiply on acceptance, a single
// shared one-bit-per-cycle restoring divider then runs 16 steps to find the
// remainder modulo the frequency step and the clamp state clamps. The emit state
// loads the output register and is held while the result side stalls. A finished
// result waits in the output register while the next item is accepted. The
// throttle flag updates as each item is taken; the user must write registers
// only while no item is in flight, and the block does not enforce it.
`include "dvfs_governor_with_thermal_throttle_unit_macros.svh"

module dvfs_governor_with_thermal_throttle_unit (
   input  logic                           clock,
   input  logic                           reset,
   // Input items
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [5:0] core_index, [17:6] peak_temperature, [28:18] utilization,
   // [44:29] old_frequency, [47:45] zero
   input  logic [dgtt_pkg::ReqDataW-1:0]  req_tdata,
   // [0] core_active
   input  logic                           req_tuser,
   // Result items
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [5:0] core_id, [21:6] new_frequency, [23:22] zero
   output logic [dgtt_pkg::RspDataW-1:0]  rsp_tdata,
   // [0] throttled
   output logic                           rsp_tuser,
   // Configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dgtt_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [dgtt_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [dgtt_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                           csr_pready
);
   import dgtt_pkg::*;

   // Configuration registers
   logic [FreqW-1:0]        min_freq_ff;
   logic [FreqW-1:0]        max_freq_ff;
   logic [FreqW-1:0]        freq_step_ff;
   logic [UtilW-1:0]        up_thr_ff;
   logic [UtilW-1:0]        down_thr_ff;
   logic signed [TempW-1:0] crit_temp_ff;
   logic signed [TempW-1:0] recv_temp_ff;

   // Sequencer and datapath registers
   state_type         state_ff, state_in;
   logic              throttle_ff, throttle_in;
   logic [CoreW-1:0]  core_ff, core_in;
   logic [FreqW-1:0]  freq_ff, freq_in;
   logic [DivW-1:0]   quo_ff, quo_in;
   logic [FreqW-1:0]  rem_ff, rem_in;
   logic [FreqW-1:0]  divisor_ff, divisor_in;
   logic [DivCntW-1:0] count_ff, count_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CoreW-1:0]  rsp_core_ff, rsp_core_in;
   logic [FreqW-1:0]  rsp_freq_ff, rsp_freq_in;
   logic              rsp_thr_ff, rsp_thr_in;

   // Unpacked input fields
   logic [CoreW-1:0]        in_core;
   logic signed [TempW-1:0] in_peak;
   logic [UtilW-1:0]        in_util;
   logic [FreqW-1:0]        in_old;
   logic                    in_active;
   logic                    req_fire;
   logic                    csr_write;

   // Shared divider step
   logic [FreqW:0]    div_trial;
   logic [FreqW+1:0]  div_diff;
   logic              div_ge;
   logic [FreqW-1:0]  div_rem;
   logic [DivW-1:0]   div_quo;
   logic [ScaleProdW-1:0] scale_prod;
   logic [FreqW-1:0]  scaled_old;
   logic [FreqW-1:0]  lowered;
   logic              out_free;

   assign in_core   = req_tdata[5:0];
   assign in_peak   = req_tdata[17:6];
   assign in_util   = req_tdata[28:18];
   assign in_old    = req_tdata[44:29];
   assign in_active = req_tuser;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Register write and read-back
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_freq_ff  <= MinFreqReset;
         max_freq_ff  <= MaxFreqReset;
         freq_step_ff <= FreqStepReset;
         up_thr_ff    <= UpThrReset;
         down_thr_ff  <= DownThrReset;
         crit_temp_ff <= CritTempReset;
         recv_temp_ff <= RecvTempReset;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            RegMinFreq:  min_freq_ff  <= csr_pwdata[FreqW-1:0];
            RegMaxFreq:  max_freq_ff  <= csr_pwdata[FreqW-1:0];
            RegFreqStep: freq_step_ff <= csr_pwdata[FreqW-1:0];
            RegUpThr:    up_thr_ff    <= csr_pwdata[UtilW-1:0];
            RegDownThr:  down_thr_ff  <= csr_pwdata[UtilW-1:0];
            RegCritTemp: crit_temp_ff <= csr_pwdata[TempW-1:0];
            RegRecvTemp: recv_temp_ff <= csr_pwdata[TempW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         RegMinFreq:  csr_prdata = {16'd0, min_freq_ff};
         RegMaxFreq:  csr_prdata = {16'd0, max_freq_ff};
         RegFreqStep: csr_prdata = {16'd0, freq_step_ff};
         RegUpThr:    csr_prdata = {21'd0, up_thr_ff};
         RegDownThr:  csr_prdata = {21'd0, down_thr_ff};
         RegCritTemp: csr_prdata = {20'd0, crit_temp_ff};
         RegRecvTemp: csr_prdata = {20'd0, recv_temp_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign div_trial = {rem_ff, quo_ff[DivW-1]};
   assign div_diff  = {1'b0, div_trial} - {2'b00, divisor_ff};
   assign div_ge    = !div_diff[FreqW+1];
   assign div_rem   = div_ge ? div_diff[FreqW-1:0] : div_trial[FreqW-1:0];
   assign div_quo   = {quo_ff[DivW-2:0], div_ge};

   // floor(old * 7 / 10) by reciprocal multiply
   assign scale_prod = {{ScaleRecipW{1'b0}}, in_old} * ScaleProdW'(ScaleRecip);
   assign scaled_old = scale_prod[ScaleShift +: FreqW];

   // Drop the remainder to round down to a whole step
   assign lowered = freq_ff - rem_ff;

   // Sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      throttle_in  = throttle_ff;
      core_in      = core_ff;
      freq_in      = freq_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_core_in  = rsp_core_ff;
      rsp_freq_in  = rsp_freq_ff;
      rsp_thr_in   = rsp_thr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               core_in = in_core;
               // Hysteresis: the critical test wins
               if (in_peak > crit_temp_ff) begin
                  throttle_in = 1'b1;
               end else if (in_peak < recv_temp_ff) begin
                  throttle_in = 1'b0;
               end
               state_in = ST_EMIT;
               if (throttle_in || !in_active) begin
                  freq_in = min_freq_ff;
               end else if (in_util > up_thr_ff) begin
                  freq_in = max_freq_ff;
               end else if (in_util < down_thr_ff) begin
                  // Scaled value fits 16 bits; divide it by the step next
                  freq_in    = scaled_old;
                  quo_in     = scaled_old;
                  rem_in     = '0;
                  divisor_in = (freq_step_ff == '0) ? FreqW'(1) : freq_step_ff;
                  count_in   = DivLastCount;
                  state_in   = ST_ROUND;
               end else begin
                  freq_in = in_old;
               end
            end
         end
         ST_ROUND: begin
            quo_in   = div_quo;
            rem_in   = div_rem;
            count_in = count_ff - DivCntW'(1);
            if (count_ff == '0) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            freq_in  = (lowered < min_freq_ff) ? min_freq_ff : lowered;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_core_in  = core_ff;
               rsp_freq_in  = freq_ff;
               rsp_thr_in   = throttle_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         throttle_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         throttle_ff  <= throttle_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      core_ff     <= core_in;
      freq_ff     <= freq_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      rsp_core_ff <= rsp_core_in;
      rsp_freq_ff <= rsp_freq_in;
      rsp_thr_ff  <= rsp_thr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_freq_ff, rsp_core_ff};
   assign rsp_tuser  = rsp_thr_ff;

   // Checks
   `DGTT_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `DGTT_ASSERT_NEXT(a_throttle_only_on_accept, !(req_tvalid && req_tready), $stable(throttle_ff))
   `DGTT_ASSERT_NOW(a_rem_below_step, state_ff == ST_CLAMP, rem_ff < divisor_ff)
   `DGTT_ASSERT_NOW(a_result_from_emit, $rose(rsp_tvalid), $past(state_ff == ST_EMIT))

endmodule

### tb/dvfs_governor_with_thermal_throttle_unit_test.sv
// Self-checking testbench of the DVFS governor with thermal throttle, driven over its streams.
module dvfs_governor_with_thermal_throttle_unit_test;
   import dgtt_pkg::*;

   localparam int ClockHalf    = 4;
   localparam int ResetCycles  = 10;
   localparam int PhaseItems   = 133;
   localparam int RandomPhases = 7;
   localparam int HangLimit    = 2000;
   localparam int SettleCycles = 50;
   localparam int IdlePause    = 4;

   typedef struct packed {
      logic [CoreW-1:0] core;
      logic [TempW-1:0] peak;
      logic             active;
      logic [UtilW-1:0] util;
      logic [FreqW-1:0] old_freq;
   } decision_type;

   typedef struct packed {
      logic [CoreW-1:0] core_id;
      logic [FreqW-1:0] new_freq;
      logic             throttled;
   } verdict_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   // [5:0] core_index, [17:6] peak_temperature, [28:18] utilization,
   // [44:29] old_frequency, [47:45] zero
   logic [ReqDataW-1:0] req_tdata;
   // [0] core_active
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // [5:0] core_id, [21:6] new_frequency, [23:22] zero
   logic [RspDataW-1:0] rsp_tdata;
   // [0] throttled
   logic                rsp_tuser;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   // Governor settings and throttle flag as the predictor sees them
   logic [FreqW-1:0]        lim_min;
   logic [FreqW-1:0]        lim_max;
   logic [FreqW-1:0]        lim_step;
   logic [UtilW-1:0]        thr_up;
   logic [UtilW-1:0]        thr_down;
   logic signed [TempW-1:0] temp_crit;
   logic signed [TempW-1:0] temp_recv;
   logic                    hot_mode;

   decision_type pending_decisions[$];
   verdict_type  awaited_verdicts[$];
   int        issued_total;
   int        settled_total;
   int        fail_count;
   int        dead_cycles;
   int        req_gap;
   int        rsp_stall;
   logic      req_took;
   logic      steady;

   dvfs_governor_with_thermal_throttle_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   // Update the throttle flag, then choose the core's new frequency
   function automatic verdict_type govern(decision_type d);
      verdict_type v;
      logic [31:0] divisor;
      logic [31:0] scaled;
      if ($signed(d.peak) > temp_crit) begin
         hot_mode = 1'b1;
      end else if ($signed(d.peak) < temp_recv) begin
         hot_mode = 1'b0;
      end
      v.core_id   = d.core;
      v.throttled = hot_mode;
      if (hot_mode || !d.active) begin
         v.new_freq = lim_min;
      end else if (d.util > thr_up) begin
         v.new_freq = lim_max;
      end else if (d.util < thr_down) begin
         // a zero step means no rounding at all
         divisor = (lim_step == '0) ? 32'd1 : 32'(lim_step);
         scaled  = 32'(d.old_freq) * 32'(ScaleNum) / 32'(ScaleDen);
         scaled  = (scaled / divisor) * divisor;
         v.new_freq = (scaled < 32'(lim_min)) ? lim_min : scaled[FreqW-1:0];
      end else begin
         v.new_freq = d.old_freq;
      end
      return v;
   endfunction

   function automatic decision_type make_decision(int core, int peak, int active, int util,
                                                  int old_freq);
      decision_type d;
      d.core     = CoreW'(core);
      d.peak     = TempW'(peak);
      d.active   = (active != 0);
      d.util     = UtilW'(util);
      d.old_freq = FreqW'(old_freq);
      return d;
   endfunction

   // Peak temperature of one epoch: in half the draws close to either hysteresis edge
   function automatic logic [TempW-1:0] pick_peak();
      case ($urandom_range(0, 3))
         0: return TempW'($urandom);
         1: return temp_crit + TempW'($urandom_range(0, 8)) - TempW'(4);
         2: return temp_recv + TempW'($urandom_range(0, 8)) - TempW'(4);
         default: return TempW'($urandom_range(0, 2400)) - TempW'(400);
      endcase
   endfunction

   function automatic decision_type random_decision(logic [TempW-1:0] peak);
      decision_type d;
      d.core   = CoreW'($urandom);
      d.peak   = peak;
      d.active = ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 4))
         0: d.util = UtilW'($urandom);
         1: d.util = thr_up + UtilW'($urandom_range(0, 4)) - UtilW'(2);
         2: d.util = thr_down + UtilW'($urandom_range(0, 4)) - UtilW'(2);
         default: d.util = UtilW'($urandom_range(0, 1024));
      endcase
      d.old_freq = FreqW'($urandom);
      return d;
   endfunction

   function automatic void enqueue(decision_type d);
      pending_decisions.push_back(d);
      issued_total++;
   endfunction

   // Write one register over the configuration port and mirror it
   task automatic program_register(input logic [2:0] index, input logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrW'({index, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         RegMinFreq:  lim_min   = value[FreqW-1:0];
         RegMaxFreq:  lim_max   = value[FreqW-1:0];
         RegFreqStep: lim_step  = value[FreqW-1:0];
         RegUpThr:    thr_up    = value[UtilW-1:0];
         RegDownThr:  thr_down  = value[UtilW-1:0];
         RegCritTemp: temp_crit = value[TempW-1:0];
         RegRecvTemp: temp_recv = value[TempW-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int fmin, input int fmax, input int fstep, input int up,
                                 input int down, input int crit, input int recv);
      program_register(RegMinFreq, CsrDataW'(fmin));
      program_register(RegMaxFreq, CsrDataW'(fmax));
      program_register(RegFreqStep, CsrDataW'(fstep));
      program_register(RegUpThr, CsrDataW'(up));
      program_register(RegDownThr, CsrDataW'(down));
      program_register(RegCritTemp, CsrDataW'(crit));
      program_register(RegRecvTemp, CsrDataW'(recv));
   endtask

   // Hold until every issued item has produced its result
   task automatic drain_block();
      while (settled_total < issued_total) @(negedge clock);
      repeat (IdlePause) @(negedge clock);
   endtask

   // Feed items from the pending queue, with random gaps between them
   always @(negedge clock) begin
      decision_type d;
      if (!reset && (!req_tvalid || req_took)) begin
         if (req_gap != 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_decisions.size() != 0) begin
            d = pending_decisions.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {3'b000, d.old_freq, d.util, d.peak, d.core};
            req_tuser  <= d.active;
            if (!steady && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 12);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the result side in random bursts
   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(0, 7) == 0) rsp_stall = $urandom_range(1, 12);
      end
   end

   // Predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      decision_type d;
      verdict_type  want;
      req_took <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         d.core     = req_tdata[5:0];
         d.peak     = req_tdata[17:6];
         d.util     = req_tdata[28:18];
         d.old_freq = req_tdata[44:29];
         d.active   = req_tuser;
         awaited_verdicts.push_back(govern(d));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         settled_total++;
         if (awaited_verdicts.size() == 0) begin
            $error("result for core %0d with no decision outstanding", rsp_tdata[5:0]);
            fail_count++;
         end else begin
            want = awaited_verdicts.pop_front();
            if (rsp_tdata[5:0] !== want.core_id) begin
               $error("core_id: expected %0d, got %0d", want.core_id, rsp_tdata[5:0]);
               fail_count++;
            end
            if (rsp_tdata[21:6] !== want.new_freq) begin
               $error("new_frequency: expected %0d, got %0d", want.new_freq, rsp_tdata[21:6]);
               fail_count++;
            end
            if (rsp_tuser !== want.throttled) begin
               $error("throttled: expected %0d, got %0d", want.throttled, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         dead_cycles <= 0;
      else
         dead_cycles <= dead_cycles + 1;
      if (dead_cycles >= HangLimit) begin
         $display("dvfs_governor_with_thermal_throttle_unit verification failed");
         $finish;
      end
   end

   initial begin
      int                      phase;
      int                      count;
      int                      run;
      int                      crit;
      int                      recv;
      int                      fmin;
      int                      fmax;
      int                      fstep;
      int                      up;
      int                      down;
      logic [TempW-1:0]        epoch_peak;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_took    = 1'b0;
      steady      = 1'b0;
      req_gap     = 0;
      rsp_stall   = 0;
      dead_cycles = 0;
      fail_count  = 0;
      issued_total  = 0;
      settled_total = 0;
      lim_min   = MinFreqReset;
      lim_max   = MaxFreqReset;
      lim_step  = FreqStepReset;
      thr_up    = UpThrReset;
      thr_down  = DownThrReset;
      temp_crit = CritTempReset;
      temp_recv = RecvTempReset;
      hot_mode  = 1'b0;

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: each utilization band, threshold equality, throttle hysteresis
      enqueue(make_decision(0, 250, 1, 1024, 2000));
      enqueue(make_decision(63, 250, 1, 0, 2000));
      enqueue(make_decision(1, 250, 1, 717, 2500));
      enqueue(make_decision(2, 250, 1, 307, 2500));
      enqueue(make_decision(3, 250, 1, 306, 65535));
      enqueue(make_decision(4, 250, 1, 0, 0));
      enqueue(make_decision(5, 250, 0, 1024, 3000));
      enqueue(make_decision(6, 801, 1, 1024, 3000));
      enqueue(make_decision(7, 790, 1, 1024, 3000));
      enqueue(make_decision(7, 790, 1, 1024, 3000));
      enqueue(make_decision(8, 779, 1, 1024, 3000));
      enqueue(make_decision(9, 790, 1, 0, 3000));
      enqueue(make_decision(10, 2047, 1, 2047, 1));
      enqueue(make_decision(11, -2048, 1, 2047, 1));
      enqueue(make_decision(12, 500, 1, 1500, 300));
      drain_block();

      // Zero step, full frequency span, thresholds at the top of their range
      apply_settings(0, 65535, 0, 1024, 1024, 2000, -400);
      enqueue(make_decision(13, 0, 1, 0, 65535));
      enqueue(make_decision(14, 0, 1, 1023, 1));
      enqueue(make_decision(15, 0, 1, 1024, 777));
      enqueue(make_decision(16, 2000, 1, 1025, 777));
      enqueue(make_decision(17, -400, 1, 2047, 5));
      drain_block();

      // Inverted limits and inverted temperatures, largest step, zero thresholds
      apply_settings(65535, 0, 65535, 0, 0, -2048, 2047);
      enqueue(make_decision(18, -2048, 1, 0, 1000));
      enqueue(make_decision(19, -2047, 1, 1, 1000));
      enqueue(make_decision(20, 2047, 1, 1, 1000));
      enqueue(make_decision(21, -2048, 1, 1, 1000));
      enqueue(make_decision(22, -2048, 0, 0, 0));
      drain_block();

      // Random epochs: one peak temperature shared by a run of cores
      for (phase = 0; phase < RandomPhases; phase++) begin
         if (phase == RandomPhases - 1) begin
            steady = 1'b1;
            apply_settings(1000, 4000, 100, 717, 307, 800, 780);
         end else begin
            fmin  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                                : int'($urandom_range(200, 1500));
            fmax  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                                : int'($urandom_range(2000, 5000));
            case ($urandom_range(0, 4))
               0: fstep = 0;
               1: fstep = $urandom_range(1, 65535);
               default: fstep = $urandom_range(1, 250);
            endcase
            up    = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 2047))
                                                : int'($urandom_range(500, 1024));
            down  = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 2047))
                                                : int'($urandom_range(0, 500));
            crit  = int'($urandom_range(0, 2400)) - 400;
            recv  = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 4095)) - 2048
                                                : crit - int'($urandom_range(0, 60));
            apply_settings(fmin, fmax, fstep, up, down, crit, recv);
         end
         count = 0;
         while (count < PhaseItems) begin
            epoch_peak = pick_peak();
            run = $urandom_range(1, 8);
            repeat (run) enqueue(random_decision(epoch_peak));
            count += run;
         end
         drain_block();
      end

      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0)
         $display("dvfs_governor_with_thermal_throttle_unit verification clean");
      else
         $display("dvfs_governor_with_thermal_throttle_unit verification failed");
      $finish;
   end

endmodule
